### hw/rtl/ecgmx_pkg.sv
package ecgmx_pkg;

	// fixed field widths
	localparam int SMP_W      = 12;
	localparam int TV_W       = 13;
	localparam int POS_W      = 12;
	localparam int SLOT_OUT_W = 5;
	localparam int CFG_W      = 12;

	// register port
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	// transform scaling: (max + min - 2x) * GAIN >> GAIN_SHIFT
	localparam int GAIN       = 10;
	localparam int GAIN_SHIFT = 4;

	localparam logic [CFG_W-1:0] PEAK_THR_RST = 12'd140;
	localparam logic [CFG_W-1:0] FEAT_THR_RST = 12'd5;

	// register indexes
	localparam logic REG_PEAK_THR = 1'b0;
	localparam logic REG_FEAT_THR = 1'b1;

	// default sizing
	localparam int RING_DEPTH_DEF  = 512;
	localparam int HALF_WINDOW_DEF = 16;
	localparam int LOOK_MARGIN_DEF = 40;
	localparam int LAPS_DEF        = 4;
	localparam int TABLE_SLOTS_DEF = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_CALC,
		ST_DECIDE
	} seq_state_t;

	// window accumulator control
	typedef struct packed {
		logic clear;
		logic valid;
	} win_ctl_t;

endpackage

### hw/rtl/ecgmx_ring.sv
module ecgmx_ring #(
	parameter int RING_DEPTH = ecgmx_pkg::RING_DEPTH_DEF,
	localparam int AW = $clog2(RING_DEPTH),
	localparam int CW = $clog2(RING_DEPTH + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 we,
	input  logic [AW-1:0]                        waddr,
	input  logic signed [ecgmx_pkg::SMP_W-1:0]   wdata,
	input  logic                                 re,
	input  logic [AW-1:0]                        raddr,
	output logic signed [ecgmx_pkg::SMP_W-1:0]   rdata
);
	import ecgmx_pkg::*;

	logic [SMP_W-1:0] mem [RING_DEPTH];
	logic [SMP_W-1:0] rd_q;
	logic             rd_ok_q;
	logic [CW-1:0]    fill_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rd_q <= mem[raddr];
	end

	// writes run in order from entry 0, so entries at or above the fill count read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (we && fill_q != CW'(RING_DEPTH))
				fill_q <= fill_q + 1'b1;
			if (re)
				rd_ok_q <= CW'(raddr) < fill_q;
		end
	end

	assign rdata = rd_ok_q ? rd_q : '0;

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re))
		else $error("ring written and read in the same cycle");

endmodule

### hw/rtl/ecgmx_window.sv
module ecgmx_window #(
	parameter int HALF_WINDOW = ecgmx_pkg::HALF_WINDOW_DEF,
	localparam int LAST = 2 * HALF_WINDOW + 2,
	localparam int KW = $clog2(LAST + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ecgmx_pkg::win_ctl_t                ctl,
	input  logic [KW-1:0]                      tap,
	input  logic signed [ecgmx_pkg::SMP_W-1:0] rd_data,
	output logic signed [ecgmx_pkg::TV_W-1:0]  tf_d,
	output logic signed [ecgmx_pkg::TV_W-1:0]  tf_m,
	output logic signed [ecgmx_pkg::TV_W-1:0]  tf_o,
	output logic signed [ecgmx_pkg::SMP_W-1:0] raw_mid
);
	import ecgmx_pkg::*;

	logic signed [TV_W-1:0]  tf_all [3];
	logic signed [SMP_W-1:0] cx_all [3];

	// three overlapping windows over one sweep: window j covers taps j .. j+2S
	for (genvar j = 0; j < 3; j++) begin : g_acc
		logic signed [SMP_W-1:0] mx_q, mn_q, cx_q;
		logic                    in_win, is_ctr;
		logic signed [SMP_W+1:0] sum;
		logic signed [SMP_W+5:0] scaled, shifted;

		assign in_win = (tap >= KW'(j)) && (tap <= KW'(j + 2 * HALF_WINDOW));
		assign is_ctr = tap == KW'(j + HALF_WINDOW);

		always_ff @(posedge clk) begin
			if (ctl.clear) begin
				mx_q <= '0;
				mn_q <= '0;
			end else if (ctl.valid && in_win) begin
				if (rd_data > mx_q)
					mx_q <= rd_data;
				if (rd_data < mn_q)
					mn_q <= rd_data;
			end
			if (ctl.valid && is_ctr)
				cx_q <= rd_data;
		end

		assign cx_all[j] = cx_q;

		assign sum = (SMP_W+2)'(mx_q) + (SMP_W+2)'(mn_q) - ((SMP_W+2)'(cx_q) <<< 1);
		assign scaled = (SMP_W+6)'(sum) * (SMP_W+6)'(GAIN);
		// arithmetic shift gives the floor for negative values
		assign shifted = scaled >>> GAIN_SHIFT;
		assign tf_all[j] = shifted[TV_W-1:0];
	end

	assign tf_d    = tf_all[0];
	assign tf_m    = tf_all[1];
	assign tf_o    = tf_all[2];
	assign raw_mid = cx_all[1];

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.valid |-> tap <= KW'(LAST))
		else $error("window tap beyond sweep");

	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |-> !ctl.valid)
		else $error("window cleared while data arrives");

endmodule

### hw/rtl/ecgmx_apb.sv
module ecgmx_apb (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ecgmx_pkg::APB_AW-1:0]      paddr,
	input  logic [ecgmx_pkg::APB_DW-1:0]      pwdata,
	output logic [ecgmx_pkg::APB_DW-1:0]      prdata,
	output logic                              pready,
	output logic [ecgmx_pkg::CFG_W-1:0]       peak_thr,
	output logic [ecgmx_pkg::CFG_W-1:0]       feat_thr
);
	import ecgmx_pkg::*;

	logic             wr_en;
	logic             reg_sel;
	logic [CFG_W-1:0] peak_thr_q, feat_thr_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_thr_q <= PEAK_THR_RST;
			feat_thr_q <= FEAT_THR_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_PEAK_THR: peak_thr_q <= pwdata[CFG_W-1:0];
				REG_FEAT_THR: feat_thr_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_PEAK_THR: prdata = APB_DW'(peak_thr_q);
			REG_FEAT_THR: prdata = APB_DW'(feat_thr_q);
			default:      prdata = '0;
		endcase
	end

	assign peak_thr = peak_thr_q;
	assign feat_thr = feat_thr_q;

endmodule

### hw/rtl/ecg_morph_extremum_detector.sv
// channel   | handshake              | payload
// ----------+------------------------+-----------------------------------------------
// in        | in_valid / in_stall    | sample
// out       | out_valid / out_stall  | position transform_value raw_value is_maximum
//           |                        | slot primed
// cfg       | psel penable pwrite    | paddr pwdata prdata (pready tied high)
//
// one sample is handled at a time, with in_stall held until decide, set by the single ring read port:
// one write, one sweep of 2*HALF_WINDOW+3 reads, then drain, transform and decide
// no clearing pass after reset: a fill count makes unwritten ring entries read as zero
// a result waits in the output register; a new sample transfer is taken meanwhile,
// and decide holds only when a further result meets a still stalled output register
module ecg_morph_extremum_detector #(
	parameter int RING_DEPTH  = ecgmx_pkg::RING_DEPTH_DEF,
	parameter int HALF_WINDOW = ecgmx_pkg::HALF_WINDOW_DEF,
	parameter int LOOK_MARGIN = ecgmx_pkg::LOOK_MARGIN_DEF,
	parameter int LAPS        = ecgmx_pkg::LAPS_DEF,
	parameter int TABLE_SLOTS = ecgmx_pkg::TABLE_SLOTS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [ecgmx_pkg::APB_AW-1:0]            paddr,
	input  logic [ecgmx_pkg::APB_DW-1:0]            pwdata,
	output logic [ecgmx_pkg::APB_DW-1:0]            prdata,
	output logic                                    pready,
	input  logic signed [ecgmx_pkg::SMP_W-1:0]      sample,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	output logic [ecgmx_pkg::POS_W-1:0]             position,
	output logic signed [ecgmx_pkg::TV_W-1:0]       transform_value,
	output logic signed [ecgmx_pkg::SMP_W-1:0]      raw_value,
	output logic                                    is_maximum,
	output logic [ecgmx_pkg::SLOT_OUT_W-1:0]        slot,
	output logic                                    primed,
	output logic                                    out_valid,
	input  logic                                    out_stall
);
	import ecgmx_pkg::*;

	localparam int AW       = $clog2(RING_DEPTH);
	localparam int LAST     = 2 * HALF_WINDOW + 2;
	localparam int KW       = $clog2(LAST + 1);
	localparam int LW       = (LAPS > 1) ? $clog2(LAPS) : 1;
	localparam int LVW      = $clog2(LAPS + 1);
	localparam int SW       = $clog2(TABLE_SLOTS);
	localparam int BASE_RST = (1 + LOOK_MARGIN) % RING_DEPTH;

	seq_state_t state_q, state_d;

	logic [AW-1:0] wi_q, base_q, addr_q, mid_q;
	logic [AW-1:0] wi_nx, base_nx, mid_nx, start_nx, addr_nx;
	logic [LW-1:0] lap_q;
	logic [KW-1:0] k_q, tap_s1;
	logic          rdv_s1;
	logic [SW-1:0] slot_q, slot_nx;
	logic          learning_q, learning_nx;

	logic signed [TV_W-1:0]  prior_q, prior_eff;
	logic signed [TV_W-1:0]  td_q, tm_q, to_q;
	logic signed [TV_W-1:0]  tf_d, tf_m, tf_o;
	logic signed [SMP_W-1:0] rd_data, raw_mid;

	logic [CFG_W-1:0] peak_thr, feat_thr;

	logic accept, we, re, calc, leave, load;
	win_ctl_t win_ctl;

	logic [TV_W-1:0] abs_m;
	logic            passes, plat_in, strict_max, strict_min, pend_max, pend_min, hit, max_nx;
	logic [LVW-1:0]  lapv;
	logic [31:0]     pos_full;
	logic [SW+SLOT_OUT_W-1:0] slot_ext;
	logic            out_valid_q;

	ecgmx_apb u_apb (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.peak_thr (peak_thr),
		.feat_thr (feat_thr)
	);

	ecgmx_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.waddr  (wi_q),
		.wdata  (sample),
		.re     (re),
		.raddr  (addr_q),
		.rdata  (rd_data)
	);

	ecgmx_window #(.HALF_WINDOW(HALF_WINDOW)) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (win_ctl),
		.tap     (tap_s1),
		.rd_data (rd_data),
		.tf_d    (tf_d),
		.tf_m    (tf_m),
		.tf_o    (tf_o),
		.raw_mid (raw_mid)
	);

	// ring pointer arithmetic
	assign wi_nx    = (wi_q == AW'(RING_DEPTH - 1)) ? '0 : wi_q + 1'b1;
	assign base_nx  = (base_q == AW'(RING_DEPTH - 1)) ? '0 : base_q + 1'b1;
	assign mid_nx   = (base_nx == AW'(RING_DEPTH - 1)) ? '0 : base_nx + 1'b1;
	assign start_nx = (base_nx >= AW'(HALF_WINDOW)) ? base_nx - AW'(HALF_WINDOW)
		: base_nx + AW'(RING_DEPTH - HALF_WINDOW);
	assign addr_nx  = (addr_q == AW'(RING_DEPTH - 1)) ? '0 : addr_q + 1'b1;

	// extremum decision on the three registered transforms
	assign abs_m      = tm_q[TV_W-1] ? TV_W'(-tm_q) : TV_W'(tm_q);
	assign passes     = (abs_m > TV_W'(peak_thr)) || (abs_m > TV_W'(feat_thr));
	assign plat_in    = (tm_q == to_q) && (tm_q != td_q) && passes;
	assign prior_eff  = plat_in ? td_q : prior_q;
	assign strict_max = (tm_q > to_q) && (tm_q > td_q);
	assign strict_min = (tm_q < to_q) && (tm_q < td_q);
	assign pend_max   = (tm_q == td_q) && (prior_eff < tm_q) && (tm_q > to_q);
	assign pend_min   = (tm_q == td_q) && (prior_eff > tm_q) && (tm_q < to_q);
	assign hit        = passes && (strict_max || strict_min || pend_max || pend_min);
	assign max_nx     = (strict_max || strict_min) ? strict_max : pend_max;

	assign lapv     = LVW'(lap_q) + LVW'(mid_q == '0);
	assign pos_full = 32'(mid_q) + 32'(RING_DEPTH) * 32'(lapv);
	assign slot_nx  = (slot_q == SW'(TABLE_SLOTS - 1)) ? '0 : slot_q + 1'b1;
	assign learning_nx = learning_q && (slot_nx != '0);
	assign slot_ext = {{SLOT_OUT_W{1'b0}}, slot_q};

	always_comb begin
		state_d = state_q;
		accept  = 1'b0;
		we      = 1'b0;
		re      = 1'b0;
		calc    = 1'b0;
		leave   = 1'b0;
		load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					accept  = 1'b1;
					we      = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				re = 1'b1;
				if (k_q == KW'(LAST))
					state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_CALC;
			ST_CALC: begin
				calc    = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				// a hit waits for room in the output register
				if (!hit || !out_valid_q || !out_stall) begin
					leave   = 1'b1;
					load    = hit;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall      = state_q != ST_IDLE;
	assign win_ctl.clear = accept;
	assign win_ctl.valid = rdv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q        <= '0;
			base_q      <= AW'(BASE_RST);
			lap_q       <= '0;
			k_q         <= '0;
			rdv_s1      <= 1'b0;
			prior_q     <= '0;
			slot_q      <= '0;
			learning_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			rdv_s1 <= re;
			if (accept) begin
				wi_q   <= wi_nx;
				base_q <= base_nx;
				k_q    <= '0;
				if (base_nx == '0)
					lap_q <= (lap_q == LW'(LAPS - 1)) ? '0 : lap_q + 1'b1;
			end
			if (re)
				k_q <= k_q + 1'b1;
			if (leave)
				prior_q <= prior_eff;
			if (load) begin
				slot_q     <= slot_nx;
				learning_q <= learning_nx;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= start_nx;
			mid_q  <= mid_nx;
		end
		if (re)
			addr_q <= addr_nx;
		tap_s1 <= k_q;
		if (calc) begin
			td_q <= tf_d;
			tm_q <= tf_m;
			to_q <= tf_o;
		end
		if (load) begin
			position        <= pos_full[POS_W-1:0];
			transform_value <= tm_q;
			raw_value       <= raw_mid;
			is_maximum      <= max_nx;
			slot            <= slot_ext[SLOT_OUT_W-1:0];
			primed          <= !learning_nx;
		end
	end

	assign out_valid = out_valid_q;

	a_accept_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_READ)
		else $error("sample transfer did not start a read sweep");

	a_result_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DECIDE))
		else $error("result appeared outside decide");

	a_learning_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!learning_q |=> !learning_q)
		else $error("learning set again after it ended");

endmodule

### verif/tb_ecg_morph_extremum_detector.sv
module tb_ecg_morph_extremum_detector;
	timeunit 1ns;
	timeprecision 1ps;

	import ecgmx_pkg::*;

	localparam int RD         = RING_DEPTH_DEF;
	localparam int HW         = HALF_WINDOW_DEF;
	localparam int ITEM_CYC   = 2 * HW + 7;
	localparam int DRAIN_CYC  = 3 * ITEM_CYC;
	localparam int QUIET_LIMIT = 5000;

	typedef struct packed {
		logic [POS_W-1:0]        position;
		logic signed [TV_W-1:0]  transform_value;
		logic signed [SMP_W-1:0] raw_value;
		logic                    is_maximum;
		logic [SLOT_OUT_W-1:0]   slot;
		logic                    primed;
	} extremum_t;

	// predicts the extremum stream and checks what the block emits
	class extremum_book;
		logic signed [SMP_W-1:0] ring [RD];
		int unsigned             wr_idx;
		int unsigned             lap;
		int unsigned             slot_idx;
		int                      prior;
		bit                      seen;
		bit                      learning;
		logic [CFG_W-1:0]        peak_thr;
		logic [CFG_W-1:0]        feat_thr;
		extremum_t               pending_extrema[$];
		int                      mismatches;

		function new();
			foreach (ring[i]) ring[i] = '0;
			wr_idx = 0;
			lap = 0;
			slot_idx = 0;
			prior = 0;
			seen = 0;
			learning = 1;
			peak_thr = PEAK_THR_RST;
			feat_thr = FEAT_THR_RST;
			mismatches = 0;
		endfunction

		function void set_threshold(logic idx, logic [APB_DW-1:0] data);
			if (idx == REG_PEAK_THR) peak_thr = data[CFG_W-1:0];
			else feat_thr = data[CFG_W-1:0];
		endfunction

		// (max + min - 2x) * gain, floored shift; max and min start at zero
		function int morph_at(int unsigned c);
			int mx;
			int mn;
			int v;
			mx = 0;
			mn = 0;
			for (int k = 0; k <= 2 * HW; k++) begin
				v = int'(ring[(c + RD - HW + k) % RD]);
				if (v > mx) mx = v;
				if (v < mn) mn = v;
			end
			return ((mx + mn - 2 * int'(ring[c])) * GAIN) >>> GAIN_SHIFT;
		endfunction

		function void note_sample(logic signed [SMP_W-1:0] v);
			int unsigned base;
			int unsigned mid;
			int unsigned lapv;
			int unsigned pos;
			int d;
			int m;
			int o;
			int mag;
			bit passes;
			bit hit;
			bit is_max;
			extremum_t e;
			ring[wr_idx] = v;
			wr_idx = (wr_idx + 1) % RD;
			base = (wr_idx + 1 + LOOK_MARGIN_DEF) % RD;
			if (base == 0) lap = (lap + 1) % LAPS_DEF;
			mid = (base + 1) % RD;
			d = morph_at(base);
			m = morph_at(mid);
			o = morph_at((base + 2) % RD);
			mag = (m < 0) ? -m : m;
			passes = (mag > int'(peak_thr)) || (mag > int'(feat_thr));
			// plateau entry remembers the value it rose or fell from
			if (m == o && m != d && passes) prior = d;
			hit = 0;
			is_max = 0;
			if (passes && ((m > o && m > d) || (m < o && m < d))) begin
				hit = 1;
				is_max = (m > o && m > d);
			end else if (passes && m == d && ((prior < m && m > o) || (prior > m && m < o))) begin
				hit = 1;
				is_max = (prior < m && m > o);
			end
			if (!hit) return;
			lapv = lap + ((mid == 0) ? 1 : 0);
			pos = mid + RD * lapv;
			e.position = POS_W'(pos);
			e.transform_value = TV_W'(m);
			e.raw_value = ring[mid];
			e.is_maximum = is_max;
			e.slot = SLOT_OUT_W'(slot_idx);
			slot_idx = (slot_idx + 1) % TABLE_SLOTS_DEF;
			seen = 1;
			if (learning && slot_idx == 0 && seen) learning = 0;
			e.primed = !learning;
			pending_extrema.push_back(e);
		endfunction

		function void check_extremum(extremum_t got);
			extremum_t want;
			if (pending_extrema.size() == 0) begin
				mismatches++;
				$display("%0t: extremum with none pending, got %p", $time, got);
				return;
			end
			want = pending_extrema.pop_front();
			if (got.position !== want.position) begin
				mismatches++;
				$display("%0t: position expected %0d actual %0d", $time, want.position,
					got.position);
			end
			if (got.transform_value !== want.transform_value) begin
				mismatches++;
				$display("%0t: transform_value expected %0d actual %0d", $time,
					want.transform_value, got.transform_value);
			end
			if (got.raw_value !== want.raw_value) begin
				mismatches++;
				$display("%0t: raw_value expected %0d actual %0d", $time, want.raw_value,
					got.raw_value);
			end
			if (got.is_maximum !== want.is_maximum) begin
				mismatches++;
				$display("%0t: is_maximum expected %0b actual %0b", $time, want.is_maximum,
					got.is_maximum);
			end
			if (got.slot !== want.slot) begin
				mismatches++;
				$display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
			end
			if (got.primed !== want.primed) begin
				mismatches++;
				$display("%0t: primed expected %0b actual %0b", $time, want.primed, got.primed);
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [APB_AW-1:0]       paddr = '0;
	logic [APB_DW-1:0]       pwdata = '0;
	logic [APB_DW-1:0]       prdata;
	logic                    pready;
	logic signed [SMP_W-1:0] sample = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [POS_W-1:0]        position;
	logic signed [TV_W-1:0]  transform_value;
	logic signed [SMP_W-1:0] raw_value;
	logic                    is_maximum;
	logic [SLOT_OUT_W-1:0]   slot;
	logic                    primed;
	logic                    out_valid;
	logic                    out_stall = 1'b0;

	extremum_book sb;

	int burst_left = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	// waveform shaping state
	int shape_mode = 0;
	int shape_left = 0;
	int beat_pos = 0;
	int beat_len = 30;
	int r_amp = 800;
	int t_amp = 120;
	int drift = 0;
	int hold_val = 0;
	int hold_left = 0;

	ecg_morph_extremum_detector u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample(sample),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.position(position),
		.transform_value(transform_value),
		.raw_value(raw_value),
		.is_maximum(is_maximum),
		.slot(slot),
		.primed(primed),
		.out_valid(out_valid),
		.out_stall(out_stall)
	);

	always #5 clk = ~clk;

	// receiver backpressure: runs of stall and no stall, short and long
	always @(negedge clk) begin
		if (stall_left == 0) begin
			out_stall = ($urandom_range(0, 2) == 0);
			if (out_stall) stall_left = $urandom_range(1, $urandom_range(0, 1) ? 8 : 90);
			else stall_left = $urandom_range(1, $urandom_range(0, 1) ? 6 : 250);
		end
		stall_left--;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_extremum('{position, transform_value, raw_value, is_maximum, slot, primed});
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic signed [SMP_W-1:0] clamp_smp(int v);
		if (v > 2047) v = 2047;
		if (v < -2048) v = -2048;
		return SMP_W'(v);
	endfunction

	function automatic logic signed [SMP_W-1:0] next_ecg_sample();
		int r;
		int v;
		if (shape_left == 0) begin
			r = $urandom_range(0, 19);
			shape_mode = (r < 8) ? 0 : (r < 13) ? 1 : (r < 17) ? 2 : 3;
			shape_left = $urandom_range(16, 64);
		end
		shape_left--;
		case (shape_mode)
			0: begin
				// beat: sharp r wave, s dip, low baseline with a t bump
				if (beat_pos >= beat_len) begin
					beat_pos = 0;
					beat_len = $urandom_range(12, 50);
					r_amp = $urandom_range(0, 2047);
					if ($urandom_range(0, 4) == 0) r_amp = -r_amp;
					t_amp = $urandom_range(0, 300);
					drift = $urandom_range(0, 200) - 100;
				end
				if (beat_pos == 0) v = r_amp;
				else if (beat_pos == 1) v = -r_amp / 3;
				else begin
					v = drift + $urandom_range(0, 16) - 8;
					if (beat_pos > beat_len / 2 && beat_pos < beat_len / 2 + 6) v += t_amp;
				end
				beat_pos++;
				return clamp_smp(v);
			end
			1: begin
				if (hold_left == 0) begin
					hold_val = $urandom_range(0, 4095) - 2048;
					hold_left = $urandom_range(2, 10);
				end
				hold_left--;
				return clamp_smp(hold_val);
			end
			2: return SMP_W'($urandom_range(0, 4095));
			default: begin
				r = $urandom_range(0, 7);
				if (r < 4) return -12'sd2048;
				if (r < 6) return 12'sd2047;
				if (r == 6) return 12'sd0;
				return -12'sd1;
			end
		endcase
	endfunction

	// called at a falling edge, returns at a falling edge after the transfer and any random idle gap
	task automatic push_sample(logic signed [SMP_W-1:0] v);
		int gap;
		sample = v;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_sample(v);
		@(negedge clk);
		if (burst_left > 0) burst_left--;
		else begin
			burst_left = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(10, 60);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = $urandom_range(1, 5);
				2: gap = $urandom_range(6, 45);
				default: gap = $urandom_range(46, 120);
			endcase
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic run_random(int count);
		for (int n = 0; n < count; n++) push_sample(next_ecg_sample());
	endtask

	// all expected extrema in, then let the last sample finish its sweep
	task automatic settle();
		in_valid = 1'b0;
		while (sb.pending_extrema.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [APB_DW-1:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = APB_AW'({idx, 2'b00});
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_threshold(idx, data);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	logic signed [SMP_W-1:0] directed_smp [25] = '{
		-2048, -2048, -2048, -2048, 2047, -2048, -2048, -2048, -2048,
		0, 0, 500, 500, 500, 500, 500, 0, 0,
		-300, -300, -300, 2047, -1, 1, 0
	};

	initial begin
		sb = new();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// isolated full-scale spike, flat block, small steps; evaluated a ring lap later
		foreach (directed_smp[i]) push_sample(directed_smp[i]);
		run_random(450);

		settle();
		write_reg(REG_PEAK_THR, 32'd0);
		write_reg(REG_FEAT_THR, 32'd0);
		run_random(150);

		// only the low 12 bits of a write are kept
		settle();
		write_reg(REG_PEAK_THR, 32'h7A3C_0FFF);
		write_reg(REG_FEAT_THR, 32'hFFFF_F050);
		run_random(100);

		// only the full-scale negative transform (-2560) passes
		settle();
		write_reg(REG_PEAK_THR, 32'd2559);
		write_reg(REG_FEAT_THR, 32'd2560);
		run_random(100);

		settle();
		write_reg(REG_PEAK_THR, 32'd200);
		write_reg(REG_FEAT_THR, 32'd30);
		run_random(150);

		in_valid = 1'b0;
		while (sb.pending_extrema.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (sb.mismatches == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule
